// File: design/vna_pkg.sv
// Shared types, constants and helper functions for the vertex normal accumulator.
// No dependencies; the top level, normal unit and checker refer to it by scoped names.
package vna_pkg;

  // Store geometry and field widths
  localparam int VERTEX_COUNT   = 1024;
  localparam int COORD_BITS     = 16;
  localparam int SUM_BITS       = 24;
  localparam int IDX_BITS       = 10;
  localparam int UNIT_FRAC_BITS = 14;
  localparam int ADDR_BITS      = $clog2(VERTEX_COUNT);

  // Datapath widths of the normal unit
  localparam int DIFF_BITS  = COORD_BITS + 1;          // edge vector component
  localparam int MUL_BITS   = DIFF_BITS + 1;           // signed multiplier operand
  localparam int PROD_BITS  = 2 * MUL_BITS;            // multiplier result
  localparam int CROSS_BITS = 2 * DIFF_BITS + 1;       // cross product component
  localparam int MAG_BITS   = 2 * DIFF_BITS;           // its magnitude
  localparam int HALF_BITS  = MAG_BITS / 2;            // split for squaring
  localparam int SQ_BITS    = 2 * MAG_BITS + 2;        // squared length
  localparam int ROOT_BITS  = SQ_BITS / 2;             // length
  localparam int Q_BITS     = UNIT_FRAC_BITS + 1;      // unit magnitude, at most 1.0
  localparam int UNIT_BITS  = Q_BITS + 1;              // signed unit component
  localparam int REM_BITS   = MAG_BITS + UNIT_FRAC_BITS;
  localparam int TRIAL_BITS = ROOT_BITS + Q_BITS;
  localparam int QIDX_BITS  = $clog2(Q_BITS);

  typedef logic [IDX_BITS-1:0]  idx_t;
  typedef logic [ADDR_BITS-1:0] addr_t;

  typedef enum logic [1:0] {
    OP_LOAD = 2'd0,
    OP_FACE = 2'd1,
    OP_READ = 2'd2
  } opcode_t;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [SUM_BITS-1:0]   sum_el_t;
  typedef logic signed [UNIT_BITS-1:0]  unit_el_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } vec_t;

  typedef struct packed {
    sum_el_t x;
    sum_el_t y;
    sum_el_t z;
  } sum_t;

  typedef struct packed {
    unit_el_t x;
    unit_el_t y;
    unit_el_t z;
  } unit_t;

  // Normal unit handshake
  typedef struct packed {
    logic start;
    logic hold;   // not used by the unit; high while the sequencer waits for it
  } math_ctl_t;

  typedef struct packed {
    logic done;
    logic zero;
  } math_sts_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_POS_RD,
    ST_MATH_GO,
    ST_MATH_WAIT,
    ST_SUM_RD,
    ST_SUM_WR,
    ST_RD_ISSUE,
    ST_RD_OUT
  } top_state_t;

  typedef enum logic [2:0] {
    M_IDLE,
    M_MUL,
    M_ROOT,
    M_DLOAD,
    M_DIV,
    M_DONE
  } math_state_t;

  function automatic logic in_range(idx_t i);
    return int'(i) < VERTEX_COUNT;
  endfunction

  function automatic addr_t to_addr(idx_t i);
    return addr_t'(i);
  endfunction

  // Signed add, clamped to the sum range
  function automatic sum_el_t sat_add(sum_el_t s, unit_el_t u);
    logic signed [SUM_BITS:0] r;
    sum_el_t                  q;
    r = (SUM_BITS+1)'(s) + (SUM_BITS+1)'(u);
    if (r[SUM_BITS] != r[SUM_BITS-1]) begin
      q = r[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      q = r[SUM_BITS-1:0];
    end
    return q;
  endfunction

endpackage

// File: design/vertex_normal_accumulator_top.sv
// Top level of the vertex normal accumulator: command sequencer, position and
// sum memories, output register. Uses vna_pkg, vna_ram and vna_normal_unit.
//
//  channel | direction | handshake          | word
//  in_     | input     | in_valid/in_stall  | opcode, vertex index, position, corners
//  out_    | output    | out_valid/out_stall| three normal sums, zero flag
//
// A load is written as it is accepted; a read fetches an in-range sum and waits
// for the output register; a face reads its three corners, runs the normal unit
// (multiplies, root, three divisions) and updates three sums unless zero-length.
// After reset a clearing pass writes zero to all 1024 sum entries, one per
// cycle, while in_stall stays high.
// A waiting read word does not block input; a further read holds until it drains.
module vertex_normal_accumulator_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [vna_pkg::IDX_BITS-1:0]  in_vertex_index,
  input  logic signed [vna_pkg::COORD_BITS-1:0] in_pos_x,
  input  logic signed [vna_pkg::COORD_BITS-1:0] in_pos_y,
  input  logic signed [vna_pkg::COORD_BITS-1:0] in_pos_z,
  input  logic [vna_pkg::IDX_BITS-1:0]  in_corner_a,
  input  logic [vna_pkg::IDX_BITS-1:0]  in_corner_b,
  input  logic [vna_pkg::IDX_BITS-1:0]  in_corner_c,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [vna_pkg::SUM_BITS-1:0] out_sum_x,
  output logic signed [vna_pkg::SUM_BITS-1:0] out_sum_y,
  output logic signed [vna_pkg::SUM_BITS-1:0] out_sum_z,
  output logic                          out_normal_is_zero
);

  vna_pkg::top_state_t state_r, state_nxt;
  logic [1:0]          cnt_r, cnt_nxt;
  vna_pkg::addr_t      clr_r, clr_nxt;
  logic                out_valid_r, out_valid_nxt;

  vna_pkg::idx_t ca_r, cb_r, cc_r, rd_idx_r;
  logic          oor_r;
  vna_pkg::vec_t pa_r, pb_r, pc_r;
  vna_pkg::sum_t out_sum_r;
  logic          out_zero_r;

  logic          accept, out_free, load_out;
  vna_pkg::idx_t corner_sel;
  vna_pkg::sum_t rd_sum, upd_sum;

  logic                      pos_we, pos_re, sum_we, sum_re;
  vna_pkg::addr_t            sum_waddr, sum_raddr;
  vna_pkg::sum_t             sum_wdata;
  vna_pkg::vec_t             pos_wdata, pos_rdata;
  logic [$bits(vna_pkg::sum_t)-1:0] sum_rdata;

  vna_pkg::math_ctl_t math_ctl;
  vna_pkg::math_sts_t math_sts;
  vna_pkg::unit_t     unit;

  assign in_stall = (state_r != vna_pkg::ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign corner_sel = (cnt_r == 2'd0) ? ca_r : (cnt_r == 2'd1) ? cb_r : cc_r;
  assign rd_sum     = vna_pkg::sum_t'(sum_rdata);

  // saturating update of the sum read for the current corner
  assign upd_sum.x = vna_pkg::sat_add(rd_sum.x, unit.x);
  assign upd_sum.y = vna_pkg::sat_add(rd_sum.y, unit.y);
  assign upd_sum.z = vna_pkg::sat_add(rd_sum.z, unit.z);

  // memories
  assign pos_we    = accept && (in_opcode == vna_pkg::OP_LOAD) &&
                     vna_pkg::in_range(in_vertex_index);
  assign pos_wdata = '{x: in_pos_x, y: in_pos_y, z: in_pos_z};
  assign pos_re    = (state_r == vna_pkg::ST_POS_RD) && (cnt_r != 2'd3);

  assign sum_we    = (state_r == vna_pkg::ST_CLEAR) || (state_r == vna_pkg::ST_SUM_WR);
  assign sum_waddr = (state_r == vna_pkg::ST_CLEAR) ? clr_r : vna_pkg::to_addr(corner_sel);
  assign sum_wdata = (state_r == vna_pkg::ST_CLEAR) ? '0 : upd_sum;
  assign sum_re    = (state_r == vna_pkg::ST_SUM_RD) || (state_r == vna_pkg::ST_RD_ISSUE);
  assign sum_raddr = (state_r == vna_pkg::ST_RD_ISSUE) ? vna_pkg::to_addr(rd_idx_r)
                                                       : vna_pkg::to_addr(corner_sel);

  vna_ram #(
    .WIDTH ($bits(vna_pkg::vec_t)),
    .DEPTH (vna_pkg::VERTEX_COUNT)
  ) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (vna_pkg::to_addr(in_vertex_index)),
    .wdata (pos_wdata),
    .re    (pos_re),
    .raddr (vna_pkg::to_addr(corner_sel)),
    .rdata (pos_rdata)
  );

  vna_ram #(
    .WIDTH ($bits(vna_pkg::sum_t)),
    .DEPTH (vna_pkg::VERTEX_COUNT)
  ) u_sum_ram (
    .clk   (clk),
    .we    (sum_we),
    .waddr (sum_waddr),
    .wdata (sum_wdata),
    .re    (sum_re),
    .raddr (sum_raddr),
    .rdata (sum_rdata)
  );

  assign math_ctl.start = (state_r == vna_pkg::ST_MATH_GO);
  assign math_ctl.hold  = (state_r == vna_pkg::ST_MATH_WAIT);

  vna_normal_unit u_normal (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (math_ctl),
    .pa    (pa_r),
    .pb    (pb_r),
    .pc    (pc_r),
    .sts   (math_sts),
    .unit  (unit)
  );

  // command sequencer
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    load_out      = 1'b0;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      vna_pkg::ST_CLEAR: begin
        clr_nxt = clr_r + 1'b1;
        if (clr_r == vna_pkg::ADDR_BITS'(vna_pkg::VERTEX_COUNT - 1)) begin
          state_nxt = vna_pkg::ST_IDLE;
        end
      end
      vna_pkg::ST_IDLE: begin
        if (accept) begin
          if (in_opcode == vna_pkg::OP_FACE) begin
            if (vna_pkg::in_range(in_corner_a) && vna_pkg::in_range(in_corner_b) &&
                vna_pkg::in_range(in_corner_c)) begin
              cnt_nxt   = '0;
              state_nxt = vna_pkg::ST_POS_RD;
            end
          end else if (in_opcode == vna_pkg::OP_READ) begin
            state_nxt = vna_pkg::in_range(in_vertex_index) ? vna_pkg::ST_RD_ISSUE
                                                           : vna_pkg::ST_RD_OUT;
          end
        end
      end
      vna_pkg::ST_POS_RD: begin
        cnt_nxt = cnt_r + 2'd1;
        if (cnt_r == 2'd3) begin
          state_nxt = vna_pkg::ST_MATH_GO;
        end
      end
      vna_pkg::ST_MATH_GO: state_nxt = vna_pkg::ST_MATH_WAIT;
      vna_pkg::ST_MATH_WAIT: begin
        if (math_sts.done) begin
          cnt_nxt   = '0;
          state_nxt = math_sts.zero ? vna_pkg::ST_IDLE : vna_pkg::ST_SUM_RD;
        end
      end
      vna_pkg::ST_SUM_RD: state_nxt = vna_pkg::ST_SUM_WR;
      vna_pkg::ST_SUM_WR: begin
        cnt_nxt   = cnt_r + 2'd1;
        state_nxt = (cnt_r == 2'd2) ? vna_pkg::ST_IDLE : vna_pkg::ST_SUM_RD;
      end
      vna_pkg::ST_RD_ISSUE: state_nxt = vna_pkg::ST_RD_OUT;
      vna_pkg::ST_RD_OUT: begin
        if (out_free) begin
          load_out      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = vna_pkg::ST_IDLE;
        end
      end
      default: state_nxt = vna_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= vna_pkg::ST_CLEAR;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ca_r     <= in_corner_a;
      cb_r     <= in_corner_b;
      cc_r     <= in_corner_c;
      rd_idx_r <= in_vertex_index;
      oor_r    <= !vna_pkg::in_range(in_vertex_index);
    end
    if (state_r == vna_pkg::ST_POS_RD) begin
      case (cnt_r)
        2'd1:    pa_r <= pos_rdata;
        2'd2:    pb_r <= pos_rdata;
        2'd3:    pc_r <= pos_rdata;
        default: ;
      endcase
    end
    if (load_out) begin
      out_sum_r  <= oor_r ? '0 : rd_sum;
      out_zero_r <= oor_r || (rd_sum == '0);
    end
  end

  assign out_valid          = out_valid_r;
  assign out_sum_x          = out_sum_r.x;
  assign out_sum_y          = out_sum_r.y;
  assign out_sum_z          = out_sum_r.z;
  assign out_normal_is_zero = out_zero_r;

endmodule

// File: design/vna_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No package dependency.
module vna_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read data holds until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: design/vna_normal_unit.sv
// Face normal unit: cross product, squared length, bit-serial square root and
// three bit-serial divisions to Q1.14. Uses vna_pkg.
module vna_normal_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  vna_pkg::math_ctl_t  ctl,
  input  vna_pkg::vec_t       pa,
  input  vna_pkg::vec_t       pb,
  input  vna_pkg::vec_t       pc,
  output vna_pkg::math_sts_t  sts,
  output vna_pkg::unit_t      unit
);

  localparam int H = vna_pkg::HALF_BITS;

  vna_pkg::math_state_t state_r, state_nxt;
  logic [3:0]           step_r, step_nxt;
  logic [1:0]           comp_r, comp_nxt;
  logic [vna_pkg::QIDX_BITS-1:0] bit_r, bit_nxt;
  logic                 zero_r, zero_nxt;

  logic signed [vna_pkg::DIFF_BITS-1:0]  e1_r [3];
  logic signed [vna_pkg::DIFF_BITS-1:0]  e2_r [3];
  logic signed [vna_pkg::CROSS_BITS-1:0] n_r  [3];
  logic signed [vna_pkg::PROD_BITS-1:0]  prod_r;
  logic [vna_pkg::SQ_BITS-1:0]   sq_r, res_r, one_r;
  logic [vna_pkg::ROOT_BITS-1:0] len_r;
  logic [vna_pkg::REM_BITS-1:0]  rem_r;
  logic [vna_pkg::Q_BITS-1:0]    q_r;
  vna_pkg::unit_el_t             u_r [3];

  logic [vna_pkg::MAG_BITS-1:0]   mag [3];
  logic [H-1:0]                   hi [3];
  logic [H-1:0]                   lo [3];
  logic signed [vna_pkg::MUL_BITS-1:0] opa, opb;
  logic [vna_pkg::SQ_BITS-1:0]    sqp, root_t;
  logic [vna_pkg::TRIAL_BITS-1:0] trial, rem_ext;
  logic [vna_pkg::Q_BITS-1:0]     q_set;
  logic signed [vna_pkg::UNIT_BITS-1:0] q_ext;

  // magnitudes and halves of the cross components
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      mag[k] = vna_pkg::MAG_BITS'(n_r[k][vna_pkg::CROSS_BITS-1] ? -n_r[k] : n_r[k]);
      hi[k]  = mag[k][vna_pkg::MAG_BITS-1:H];
      lo[k]  = mag[k][H-1:0];
    end
  end

  // operand schedule of the shared multiplier
  always_comb begin
    opa = '0;
    opb = '0;
    case (step_r)
      4'd0:  begin opa = vna_pkg::MUL_BITS'(e1_r[1]); opb = vna_pkg::MUL_BITS'(e2_r[2]); end
      4'd1:  begin opa = vna_pkg::MUL_BITS'(e1_r[2]); opb = vna_pkg::MUL_BITS'(e2_r[1]); end
      4'd2:  begin opa = vna_pkg::MUL_BITS'(e1_r[2]); opb = vna_pkg::MUL_BITS'(e2_r[0]); end
      4'd3:  begin opa = vna_pkg::MUL_BITS'(e1_r[0]); opb = vna_pkg::MUL_BITS'(e2_r[2]); end
      4'd4:  begin opa = vna_pkg::MUL_BITS'(e1_r[0]); opb = vna_pkg::MUL_BITS'(e2_r[1]); end
      4'd5:  begin opa = vna_pkg::MUL_BITS'(e1_r[1]); opb = vna_pkg::MUL_BITS'(e2_r[0]); end
      4'd6:  begin opa = $signed({1'b0, hi[0]}); opb = $signed({1'b0, hi[0]}); end
      4'd7:  begin opa = $signed({1'b0, hi[0]}); opb = $signed({1'b0, lo[0]}); end
      4'd8:  begin opa = $signed({1'b0, lo[0]}); opb = $signed({1'b0, lo[0]}); end
      4'd9:  begin opa = $signed({1'b0, hi[1]}); opb = $signed({1'b0, hi[1]}); end
      4'd10: begin opa = $signed({1'b0, hi[1]}); opb = $signed({1'b0, lo[1]}); end
      4'd11: begin opa = $signed({1'b0, lo[1]}); opb = $signed({1'b0, lo[1]}); end
      4'd12: begin opa = $signed({1'b0, hi[2]}); opb = $signed({1'b0, hi[2]}); end
      4'd13: begin opa = $signed({1'b0, hi[2]}); opb = $signed({1'b0, lo[2]}); end
      4'd14: begin opa = $signed({1'b0, lo[2]}); opb = $signed({1'b0, lo[2]}); end
      default: begin opa = '0; opb = '0; end
    endcase
  end

  assign sqp     = vna_pkg::SQ_BITS'($unsigned(prod_r));
  assign root_t  = res_r + one_r;
  assign trial   = vna_pkg::TRIAL_BITS'(len_r) << bit_r;
  assign rem_ext = vna_pkg::TRIAL_BITS'(rem_r);
  assign q_set   = q_r | (vna_pkg::Q_BITS'(1) << bit_r);

  // sequencer
  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    comp_nxt  = comp_r;
    bit_nxt   = bit_r;
    zero_nxt  = zero_r;
    sts.done  = 1'b0;
    sts.zero  = zero_r;
    case (state_r)
      vna_pkg::M_IDLE: begin
        if (ctl.start) begin
          state_nxt = vna_pkg::M_MUL;
          step_nxt  = '0;
        end
      end
      vna_pkg::M_MUL: begin
        step_nxt = step_r + 4'd1;
        if (step_r == 4'd15) begin
          state_nxt = vna_pkg::M_ROOT;
        end
      end
      vna_pkg::M_ROOT: begin
        if (one_r == '0) begin
          comp_nxt = '0;
          if (res_r == '0) begin
            zero_nxt  = 1'b1;
            state_nxt = vna_pkg::M_DONE;
          end else begin
            zero_nxt  = 1'b0;
            state_nxt = vna_pkg::M_DLOAD;
          end
        end
      end
      vna_pkg::M_DLOAD: begin
        bit_nxt   = vna_pkg::QIDX_BITS'(vna_pkg::Q_BITS - 1);
        state_nxt = vna_pkg::M_DIV;
      end
      vna_pkg::M_DIV: begin
        bit_nxt = bit_r - 1'b1;
        if (bit_r == '0) begin
          if (comp_r == 2'd2) begin
            state_nxt = vna_pkg::M_DONE;
          end else begin
            comp_nxt  = comp_r + 2'd1;
            state_nxt = vna_pkg::M_DLOAD;
          end
        end
      end
      vna_pkg::M_DONE: begin
        sts.done  = 1'b1;
        state_nxt = vna_pkg::M_IDLE;
      end
      default: state_nxt = vna_pkg::M_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= vna_pkg::M_IDLE;
      step_r  <= '0;
      comp_r  <= '0;
      bit_r   <= '0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      comp_r  <= comp_nxt;
      bit_r   <= bit_nxt;
      zero_r  <= zero_nxt;
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    prod_r <= opa * opb;
    case (state_r)
      vna_pkg::M_IDLE: begin
        if (ctl.start) begin
          e1_r[0] <= vna_pkg::DIFF_BITS'(pc.x) - vna_pkg::DIFF_BITS'(pa.x);
          e1_r[1] <= vna_pkg::DIFF_BITS'(pc.y) - vna_pkg::DIFF_BITS'(pa.y);
          e1_r[2] <= vna_pkg::DIFF_BITS'(pc.z) - vna_pkg::DIFF_BITS'(pa.z);
          e2_r[0] <= vna_pkg::DIFF_BITS'(pb.x) - vna_pkg::DIFF_BITS'(pa.x);
          e2_r[1] <= vna_pkg::DIFF_BITS'(pb.y) - vna_pkg::DIFF_BITS'(pa.y);
          e2_r[2] <= vna_pkg::DIFF_BITS'(pb.z) - vna_pkg::DIFF_BITS'(pa.z);
          for (int k = 0; k < 3; k++) begin
            n_r[k] <= '0;
          end
          sq_r <= '0;
        end
      end
      vna_pkg::M_MUL: begin
        // accumulate the product issued one step earlier
        case (step_r)
          4'd1:  n_r[0] <= n_r[0] + vna_pkg::CROSS_BITS'(prod_r);
          4'd2:  n_r[0] <= n_r[0] - vna_pkg::CROSS_BITS'(prod_r);
          4'd3:  n_r[1] <= n_r[1] + vna_pkg::CROSS_BITS'(prod_r);
          4'd4:  n_r[1] <= n_r[1] - vna_pkg::CROSS_BITS'(prod_r);
          4'd5:  n_r[2] <= n_r[2] + vna_pkg::CROSS_BITS'(prod_r);
          4'd6:  n_r[2] <= n_r[2] - vna_pkg::CROSS_BITS'(prod_r);
          4'd7, 4'd10, 4'd13: sq_r <= sq_r + (sqp << (2 * H));
          4'd8, 4'd11, 4'd14: sq_r <= sq_r + (sqp << (H + 1));
          4'd9, 4'd12, 4'd15: sq_r <= sq_r + sqp;
          default: ;
        endcase
        if (step_r == 4'd15) begin
          res_r <= '0;
          one_r <= vna_pkg::SQ_BITS'(1) << (vna_pkg::SQ_BITS - 2);
        end
      end
      vna_pkg::M_ROOT: begin
        // one result bit per cycle, sq_r holds the running remainder
        if (one_r != '0) begin
          if (sq_r >= root_t) begin
            sq_r  <= sq_r - root_t;
            res_r <= (res_r >> 1) + one_r;
          end else begin
            res_r <= res_r >> 1;
          end
          one_r <= one_r >> 2;
        end else begin
          len_r <= res_r[vna_pkg::ROOT_BITS-1:0];
        end
      end
      vna_pkg::M_DLOAD: begin
        rem_r <= {mag[comp_r], {vna_pkg::UNIT_FRAC_BITS{1'b0}}};
        q_r   <= '0;
      end
      vna_pkg::M_DIV: begin
        if (rem_ext >= trial) begin
          rem_r <= vna_pkg::REM_BITS'(rem_ext - trial);
          q_r   <= q_set;
        end
        if (bit_r == '0) begin
          u_r[comp_r] <= n_r[comp_r][vna_pkg::CROSS_BITS-1] ? -q_ext : q_ext;
        end
      end
      default: ;
    endcase
  end

  // quotient including the final bit
  assign q_ext = $signed({1'b0, (rem_ext >= trial) ? q_set : q_r});

  assign unit.x = u_r[0];
  assign unit.y = u_r[1];
  assign unit.z = u_r[2];

endmodule

// File: design/vna_checker.sv
// Port-level checks for the vertex normal accumulator, bound to the top level.
// Uses vna_pkg for field widths.
module vna_checker (
  input logic                               clk,
  input logic                               rst_n,
  input logic                               in_stall,
  input logic                               out_valid,
  input logic                               out_stall,
  input logic signed [vna_pkg::SUM_BITS-1:0] out_sum_x,
  input logic signed [vna_pkg::SUM_BITS-1:0] out_sum_y,
  input logic signed [vna_pkg::SUM_BITS-1:0] out_sum_z,
  input logic                               out_normal_is_zero
);

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sum_x) && $stable(out_sum_y) &&
      $stable(out_sum_z) && $stable(out_normal_is_zero))
    else $error("stalled result word changed");

  // zero flag matches the sums
  a_zero_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_normal_is_zero ==
      (out_sum_x == '0 && out_sum_y == '0 && out_sum_z == '0))
    else $error("zero flag disagrees with sums");

  // clearing pass blocks input right after reset
  a_clear_stall: assert property (@(posedge clk) !rst_n |=> in_stall)
    else $error("input taken during clearing pass");

  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result word valid after reset");

endmodule

bind vertex_normal_accumulator_top vna_checker u_vna_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_stall           (in_stall),
  .out_valid          (out_valid),
  .out_stall          (out_stall),
  .out_sum_x          (out_sum_x),
  .out_sum_y          (out_sum_y),
  .out_sum_z          (out_sum_z),
  .out_normal_is_zero (out_normal_is_zero)
);
